>>> rtl/seed_chain_score_dp_top_defines.svh
// Assertion macros shared by the seed chain scoring RTL.
`ifndef SEED_CHAIN_SCORE_DP_TOP_DEFINES_SVH
`define SEED_CHAIN_SCORE_DP_TOP_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define SCDP_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("scdp assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SCDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scdp assertion failed");

`endif

>>> rtl/scdp_pkg.sv
// Package: shared types and constants of the seed chain scoring block.
`default_nettype none
package scdp_pkg;

  localparam int MaxAnchorsDef = 4096;
  localparam int QW = 24;
  localparam int RW = 32;
  localparam int LW = 16;
  localparam int SW = 31;
  localparam int PW = 13;
  localparam int EpochW = 8;
  localparam int CfgIw = 3;
  localparam int CfgDw = 16;

  // floor(x/100) = (x * Div100Mul) >> Div100Sh for any 32-bit x
  localparam logic [31:0] Div100Mul = 32'd1374389535;
  localparam int Div100Sh = 37;

  typedef enum logic [CfgIw-1:0] {
    REG_QGAP = 3'd0,
    REG_RGAP = 3'd1,
    REG_BAND = 3'd2,
    REG_SKIP = 3'd3,
    REG_MEAN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [QW-1:0] query_pos;
    logic [RW-1:0] reference_pos;
    logic [LW-1:0] anchor_length;
    logic          first_of_batch;
  } item_t;

  typedef struct packed {
    logic [15:0] qgap;
    logic [15:0] rgap;
    logic [15:0] band;
    logic [7:0]  skip;
    logic [15:0] mean;
  } cfg_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic [RW-1:0] r;
    logic [LW-1:0] len;
  } anchor_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_WIN, ST_WCMP, ST_NEXT, ST_CHK,
    ST_MUL, ST_DIV, ST_UPD, ST_PEAK, ST_FIN
  } scan_state_e;

  // position of the highest set bit, zero for zero
  function automatic logic [3:0] floor_log2(input logic [15:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (x[b]) n = 4'(b);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/scdp_front.sv
// Front end: input acceptance and a two-entry queue toward the scan engine.
`default_nettype none
`include "seed_chain_score_dp_top_defines.svh"
module scdp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire scdp_pkg::item_t in_item_i,
  input  wire logic           hold_i,
  output logic                q_valid_o,
  output scdp_pkg::item_t     q_item_o,
  input  wire logic           q_pop_i
);
  import scdp_pkg::*;

  item_t      buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push;

  // no new item while the mark memory is swept
  assign in_ready_o = (cnt_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (q_pop_i) rp_q <= !rp_q;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_item_i;
  end

  `SCDP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2)
  `SCDP_ASSERT(a_pop_nonempty, clk_i, rst_ni, !q_pop_i || cnt_q != 2'd0)
  `SCDP_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push && !q_pop_i,
                    cnt_q == $past(cnt_q) + 2'd1)

endmodule
`default_nettype wire

>>> rtl/scdp_back.sv
// Back end: window advance, predecessor scan, score stores and result register.
`default_nettype none
`include "seed_chain_score_dp_top_defines.svh"
module scdp_back #(
  parameter int MAX_ANCHORS = scdp_pkg::MaxAnchorsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire scdp_pkg::cfg_t  cfg_i,
  input  wire logic            q_valid_i,
  input  wire scdp_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [scdp_pkg::SW-1:0] chain_score_o,
  output logic [scdp_pkg::PW-1:0] predecessor_o,
  output logic [scdp_pkg::SW-1:0] peak_score_o
);
  import scdp_pkg::*;

  localparam int IA = $clog2(MAX_ANCHORS);
  localparam int IW = $clog2(MAX_ANCHORS + 1);
  localparam int MW = EpochW + IW;

  // memories
  anchor_t         anc_mem  [MAX_ANCHORS];
  logic [SW-1:0]   scr_mem  [MAX_ANCHORS];
  logic [IA:0]     prd_mem  [MAX_ANCHORS];
  logic [SW-1:0]   pk_mem   [MAX_ANCHORS];
  logic [MW-1:0]   mk_mem   [MAX_ANCHORS];
  anchor_t         anc_rd_q;
  logic [SW-1:0]   scr_rd_q, pk_rd_q;
  logic [IA:0]     prd_rd_q;
  logic [MW-1:0]   mk_rd_q;

  scan_state_e state_q, state_d;
  logic [IW-1:0]     cnt_q, cnt_d, ws_q, ws_d, k_q, k_d;
  logic [EpochW-1:0] ep_q, ep_d;
  logic [IA-1:0]     clr_q, clr_d;
  logic              clr_item_q, clr_item_d;
  logic [QW-1:0]     qi_q, qi_d;
  logic [RW-1:0]     ri_q, ri_d;
  logic [LW-1:0]     cov_q, cov_d;
  logic signed [33:0] best_q, best_d;
  logic [IA-1:0]     bj_q, bj_d, j_q, j_d;
  logic              bjv_q, bjv_d;
  logic [8:0]        skip_q, skip_d;
  logic              ok_d;
  logic [15:0]       dd_q, dd_d;
  logic [31:0]       base_q, base_d;
  logic              hit_q, hit_d, pv_q, pv_d;
  logic [IA-1:0]     pidx_q, pidx_d;
  logic [31:0]       prod_q, prod_d;
  logic [2:0]        lg_q, lg_d;
  logic [25:0]       quo_q, quo_d;
  logic              ov_q, ov_d;
  logic [SW-1:0]     cs_q, cs_d, pko_q, pko_d;
  logic [PW-1:0]     po_q, po_d;

  logic [IA-1:0] rd_addr, mk_waddr;
  logic [MW-1:0] mk_wdata;
  logic          mk_we, st_we;

  // candidate checks
  logic [QW:0]   q_end;
  logic [RW:0]   r_end;
  logic [RW-1:0] dr, dd;
  logic [QW-1:0] dq;
  logic [15:0]   mind, minc;
  logic          bad;
  logic [63:0]   wide;
  logic signed [33:0] sc;
  logic [SW-1:0] clamp;
  logic [31:0]   bj_ext;
  logic [3:0]    lg_full;

  always_comb begin
    q_end = {1'b0, anc_rd_q.q} + (QW+1)'(anc_rd_q.len);
    r_end = {1'b0, anc_rd_q.r} + (RW+1)'(anc_rd_q.len);
    dr    = ri_q - anc_rd_q.r;
    dq    = qi_q - anc_rd_q.q;
    dd    = (dr > RW'(dq)) ? dr - RW'(dq) : RW'(dq) - dr;
    bad   = (q_end >= {1'b0, qi_q}) || (r_end >= {1'b0, ri_q}) ||
            (dr == '0) || (dq == '0) || (dq > QW'(cfg_i.qgap)) ||
            (dr > RW'(cfg_i.rgap)) || (dd > RW'(cfg_i.band));
    mind  = (RW'(dq) < dr) ? dq[15:0] : dr[15:0];
    minc  = (mind > cov_q) ? cov_q : mind;
    wide  = 64'(prod_q) * 64'(Div100Mul);
    sc    = $signed({2'b00, base_q}) - $signed({8'b0, quo_q}) - $signed({31'b0, lg_q});
    clamp = (best_q[33:31] != 3'b000) ? {SW{1'b1}} : best_q[SW-1:0];
    bj_ext = 32'(bj_q);
    lg_full = floor_log2(dd_q);
  end

  // next state and datapath control
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ws_d = ws_q; k_d = k_q; ep_d = ep_q;
    clr_d = clr_q; clr_item_d = clr_item_q; qi_d = qi_q; ri_d = ri_q; cov_d = cov_q;
    best_d = best_q; bj_d = bj_q; bjv_d = bjv_q; skip_d = skip_q; j_d = j_q;
    dd_d = dd_q; base_d = base_q; hit_d = hit_q; pv_d = pv_q; pidx_d = pidx_q;
    prod_d = prod_q; lg_d = lg_q; quo_d = quo_q; ov_d = ov_q;
    cs_d = cs_q; pko_d = pko_q; po_d = po_q;
    ok_d = 1'b0;
    rd_addr = '0; mk_we = 1'b0; mk_waddr = '0; mk_wdata = '0; st_we = 1'b0;
    q_pop_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        mk_we = 1'b1; mk_waddr = clr_q; clr_d = clr_q + 1'b1;
        if (clr_q == IA'(MAX_ANCHORS - 1)) state_d = clr_item_q ? ST_WIN : ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          qi_d = q_item_i.query_pos; ri_d = q_item_i.reference_pos;
          cov_d = q_item_i.anchor_length;
          best_d = $signed({18'b0, q_item_i.anchor_length});
          bjv_d = 1'b0; skip_d = '0; k_d = '0; state_d = ST_WIN;
          if (q_item_i.first_of_batch) begin
            cnt_d = '0; ws_d = '0; ep_d = ep_q + 1'b1;
            if (ep_d == '0) begin
              clr_d = '0; clr_item_d = 1'b1; state_d = ST_CLR;
            end
          end
        end
      end
      ST_WIN: begin
        rd_addr = ws_q[IA-1:0];
        if (ws_q < cnt_q) state_d = ST_WCMP;
        else begin
          k_d = cnt_q; state_d = ST_NEXT;
        end
      end
      ST_WCMP: begin
        if ({1'b0, ri_q} > {1'b0, anc_rd_q.r} + (RW+1)'(cfg_i.rgap)) begin
          ws_d = ws_q + 1'b1; state_d = ST_WIN;
        end else begin
          k_d = cnt_q; state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        rd_addr = IA'(k_q - 1'b1);
        j_d = rd_addr;
        state_d = (k_q > ws_q) ? ST_CHK : ST_PEAK;
      end
      ST_CHK: begin
        ok_d   = !bad;
        dd_d   = dd[15:0];
        base_d = {1'b0, scr_rd_q} + 32'(minc);
        hit_d  = (mk_rd_q[MW-1:IW] == ep_q) && (mk_rd_q[IW-1:0] == cnt_q);
        pv_d   = prd_rd_q[IA];
        pidx_d = prd_rd_q[IA-1:0];
        if (ok_d) state_d = ST_MUL;
        else begin
          k_d = k_q - 1'b1; state_d = ST_NEXT;
        end
      end
      ST_MUL: begin
        prod_d = 32'(dd_q) * 32'(cfg_i.mean);
        lg_d = lg_full[3:1];
        state_d = ST_DIV;
      end
      ST_DIV: begin
        quo_d = wide[Div100Sh+25:Div100Sh];
        state_d = ST_UPD;
      end
      ST_UPD: begin
        k_d = k_q - 1'b1; state_d = ST_NEXT;
        if (sc > best_q) begin
          best_d = sc; bj_d = j_q; bjv_d = 1'b1;
          if (skip_q != '0) skip_d = skip_q - 1'b1;
        end else if (hit_q) begin
          skip_d = skip_q + 1'b1;
          if (skip_d > {1'b0, cfg_i.skip}) state_d = ST_PEAK;
        end
        if (state_d == ST_NEXT && pv_q) begin
          mk_we = 1'b1; mk_waddr = pidx_q; mk_wdata = {ep_q, cnt_q};
        end
      end
      ST_PEAK: begin
        rd_addr = bj_q; state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; cs_d = clamp;
          pko_d = (bjv_q && pk_rd_q > clamp) ? pk_rd_q : clamp;
          po_d = bjv_q ? bj_ext[PW-1:0] : {PW{1'b1}};
          if (cnt_q != IW'(MAX_ANCHORS)) begin
            st_we = 1'b1; cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR; cnt_q <= '0; ws_q <= '0; k_q <= '0; ep_q <= '0;
      clr_q <= '0; clr_item_q <= 1'b0; ov_q <= 1'b0; skip_q <= '0; bjv_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ws_q <= ws_d; k_q <= k_d; ep_q <= ep_d;
      clr_q <= clr_d; clr_item_q <= clr_item_d; ov_q <= ov_d; skip_q <= skip_d;
      bjv_q <= bjv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qi_q <= qi_d; ri_q <= ri_d; cov_q <= cov_d; best_q <= best_d; bj_q <= bj_d;
    j_q <= j_d; dd_q <= dd_d; base_q <= base_d; hit_q <= hit_d; pv_q <= pv_d;
    pidx_q <= pidx_d; prod_q <= prod_d; lg_q <= lg_d; quo_q <= quo_d;
    cs_q <= cs_d; pko_q <= pko_d; po_q <= po_d;
  end

  // anchor, score, predecessor and peak stores
  always_ff @(posedge clk_i) begin
    if (st_we) anc_mem[cnt_q[IA-1:0]] <= '{q: qi_q, r: ri_q, len: cov_q};
    anc_rd_q <= anc_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (st_we) scr_mem[cnt_q[IA-1:0]] <= clamp;
    scr_rd_q <= scr_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (st_we) prd_mem[cnt_q[IA-1:0]] <= {bjv_q, bj_q};
    prd_rd_q <= prd_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (st_we) pk_mem[cnt_q[IA-1:0]] <= pko_d;
    pk_rd_q <= pk_mem[rd_addr];
  end
  // visit marks, tagged with the batch epoch
  always_ff @(posedge clk_i) begin
    if (mk_we) mk_mem[mk_waddr] <= mk_wdata;
    mk_rd_q <= mk_mem[rd_addr];
  end

  assign clearing_o    = state_q == ST_CLR;
  assign out_valid_o   = ov_q;
  assign chain_score_o = cs_q;
  assign predecessor_o = po_q;
  assign peak_score_o  = pko_q;

  `SCDP_ASSERT(a_win_le_cnt, clk_i, rst_ni, ws_q <= cnt_q)
  `SCDP_ASSERT(a_k_le_cnt, clk_i, rst_ni, k_q <= cnt_q || state_q == ST_IDLE)
  `SCDP_ASSERT(a_no_pop_clr, clk_i, rst_ni, !(clearing_o && q_pop_o))
  `SCDP_ASSERT_NEXT(a_fin_out, clk_i, rst_ni,
                    state_q == ST_FIN && (!ov_q || out_ready_i), ov_q)

endmodule
`default_nettype wire

>>> rtl/seed_chain_score_dp_top.sv
// Top level: configuration registers, front queue and scan engine.
//
//  channel | valid / ready            | payload
//  input   | in_valid_i / in_ready_o  | query_pos_i, reference_pos_i, anchor_length_i,
//          |                          | first_of_batch_i
//  result  | out_valid_o / out_ready_i| chain_score_o, predecessor_o, peak_score_o
//  config  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An item's scan walks W anchors that leave the window, then C candidates that
// pass every check and F that fail one; its pace is set by the single read port
// of the anchor memory and the multiply and divide-by-100 steps.
// After reset, and every 256th batch, the visit marks are swept entry by entry,
// all MAX_ANCHORS of them, while no item is taken. A stalled result holds in the
// output register while the queue keeps taking up to two items.
`default_nettype none
module seed_chain_score_dp_top #(
  parameter int MAX_ANCHORS = scdp_pkg::MaxAnchorsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [scdp_pkg::QW-1:0]    query_pos_i,
  input  wire logic [scdp_pkg::RW-1:0]    reference_pos_i,
  input  wire logic [scdp_pkg::LW-1:0]    anchor_length_i,
  input  wire logic                       first_of_batch_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [scdp_pkg::SW-1:0]         chain_score_o,
  output logic [scdp_pkg::PW-1:0]         predecessor_o,
  output logic [scdp_pkg::SW-1:0]         peak_score_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [scdp_pkg::CfgIw-1:0] cfg_index_i,
  input  wire logic [scdp_pkg::CfgDw-1:0] cfg_data_i
);
  import scdp_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop, clearing;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{qgap: 16'd3000, rgap: 16'd3000, band: 16'd500, skip: 8'd25, mean: 16'd0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_QGAP: cfg_q.qgap <= cfg_data_i;
        REG_RGAP: cfg_q.rgap <= cfg_data_i;
        REG_BAND: cfg_q.band <= cfg_data_i;
        REG_SKIP: cfg_q.skip <= cfg_data_i[7:0];
        REG_MEAN: cfg_q.mean <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{query_pos: query_pos_i, reference_pos: reference_pos_i,
                     anchor_length: anchor_length_i, first_of_batch: first_of_batch_i};

  scdp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .hold_i(clearing), .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  scdp_back #(.MAX_ANCHORS(MAX_ANCHORS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .clearing_o(clearing), .out_valid_o, .out_ready_i,
    .chain_score_o, .predecessor_o, .peak_score_o
  );

endmodule
`default_nettype wire
